// ----- hw/rtl/oaids_pkg.sv -----
`timescale 1ns / 1ps

package oaids_pkg;

    // Default list depth and the fixed widths of the request and result fields.
    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int SLOT_W    = 7;
    localparam int FSLOT_W   = 6;
    localparam int STATUS_W  = 3;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_DISPLAY = 2'd2,
        REQ_SEARCH  = 2'd3
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADPOS   = 3'd3,
        STS_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_SEARCH,
        ST_DISP_RD,
        ST_DISP_OUT,
        ST_RESP
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic [FSLOT_W-1:0]         found_slot;
        logic signed [DATA_W-1:0]   entry_value;
        logic                       last;
    } result_t;

endpackage

// ----- hw/rtl/oaids_req_if.sv -----
`timescale 1ns / 1ps

interface oaids_req_if;
    import oaids_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [SLOT_W-1:0]          slot;
    logic signed [DATA_W-1:0]   item_value;

    modport source (output valid, output req_type, output slot, output item_value,
                    input ready);
    modport sink   (input valid, input req_type, input slot, input item_value,
                    output ready);
endinterface

// ----- hw/rtl/oaids_rsp_if.sv -----
`timescale 1ns / 1ps

interface oaids_rsp_if;
    import oaids_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [FSLOT_W-1:0]         found_slot;
    logic signed [DATA_W-1:0]   entry_value;
    logic                       last;

    modport source (output valid, output status, output found_slot, output entry_value,
                    output last, input ready);
    modport sink   (input valid, input status, input found_slot, input entry_value,
                    input last, output ready);
endinterface

// ----- hw/rtl/oaids_out_stage.sv -----
`timescale 1ns / 1ps

module oaids_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  oaids_pkg::result_t din,
    output logic              free,
    oaids_rsp_if.source       rsp
);
    import oaids_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // The stage can take a new result when empty or when its result leaves now.
    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else
        begin
            valid_next = valid_reg && !rsp.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= din;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.status      = data_reg.status;
    assign rsp.found_slot  = data_reg.found_slot;
    assign rsp.entry_value = data_reg.entry_value;
    assign rsp.last        = data_reg.last;

endmodule

// ----- hw/rtl/ordered_array_insert_delete_search_top.sv -----
`timescale 1ns / 1ps

// Channel   Modport  Direction  Payload
// req       sink     in         req_type, slot, item_value
// rsp       source   out        status, found_slot, entry_value, last
//
// Insert and delete first shift the entries that move one place along, each one
// read into the read register and written from there to its new place.
// Search reads from the first entry and stops at the first hit or the last entry.
// Display gives one result per entry, as each entry is read and then registered.
// Reset clears the fill count and the sequencer; the entry memory is not cleared.
// A stalled result holds the sequencer in place; no request is taken until idle.

module ordered_array_insert_delete_search_top #(
    parameter int DEPTH = oaids_pkg::DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    oaids_req_if.sink    req,
    oaids_rsp_if.source  rsp
);
    import oaids_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    // Sequencer and list state.
    state_t               state_reg,   state_next;
    logic [CNT_W-1:0]     count_reg,   count_next;
    logic [IDX_W-1:0]     ptr_reg,     ptr_next;
    logic [IDX_W-1:0]     wptr_reg,    wptr_next;
    logic [IDX_W-1:0]     end_reg,     end_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     pos_reg,     pos_next;
    logic [IDX_W-1:0]     res_slot_reg, res_slot_next;
    logic [DATA_W-1:0]    val_reg,     val_next;
    status_t              res_status_reg, res_status_next;
    logic                 dir_reg,     dir_next;
    logic                 pend_reg,    pend_next;
    logic                 done_reg,    done_next;

    // Entry memory: one write port, one registered read port addressed by ptr_reg.
    logic [DATA_W-1:0]    mem [DEPTH];
    logic [DATA_W-1:0]    rdata_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     waddr;
    logic [DATA_W-1:0]    wdata;

    // Result register towards the response channel.
    logic                 out_load;
    logic                 out_free;
    result_t              out_din;

    // Request decode.
    logic                 req_fire;
    req_type_t            req_kind;
    logic [SLOT_W-1:0]    cnt_ext;
    logic                 list_empty;
    logic                 reject;
    status_t              reject_status;
    logic                 no_move;
    logic [IDX_W-1:0]     last_idx;
    logic                 hit;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_fire   = req.valid && req.ready;
    assign req_kind   = req_type_t'(req.req_type);
    assign cnt_ext    = SLOT_W'(count_reg);
    assign list_empty = (count_reg == '0);
    assign last_idx   = IDX_W'(count_reg - CNT_ONE);
    assign hit        = (rdata_reg == val_reg);

    // Rejections are decided at once from the fill count and the requested slot.
    // An insert at the end or a delete of the final entry moves nothing.
    always_comb
    begin
        reject        = 1'b0;
        reject_status = STS_OK;
        no_move       = 1'b0;
        unique case (req_kind)
            REQ_INSERT:
            begin
                if (count_reg >= CNT_MAX)
                begin
                    reject        = 1'b1;
                    reject_status = STS_FULL;
                end
                else if (req.slot > cnt_ext)
                begin
                    reject        = 1'b1;
                    reject_status = STS_BADPOS;
                end
                no_move = (req.slot == cnt_ext);
            end
            REQ_DELETE:
            begin
                if (list_empty)
                begin
                    reject        = 1'b1;
                    reject_status = STS_EMPTY;
                end
                else if (req.slot >= cnt_ext)
                begin
                    reject        = 1'b1;
                    reject_status = STS_BADPOS;
                end
                no_move = (req.slot == SLOT_W'(count_reg - CNT_ONE));
            end
            REQ_DISPLAY, REQ_SEARCH:
            begin
                if (list_empty)
                begin
                    reject        = 1'b1;
                    reject_status = STS_EMPTY;
                end
            end
            default:
            begin
                reject = 1'b0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    if (reject)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        unique case (req_kind)
                            REQ_INSERT, REQ_DELETE:
                                state_next = no_move ? ST_PUT : ST_SHIFT;
                            REQ_DISPLAY:
                                state_next = ST_DISP_RD;
                            REQ_SEARCH:
                                state_next = ST_SEARCH;
                            default:
                                state_next = ST_IDLE;
                        endcase
                    end
                end
            end
            ST_SHIFT:
            begin
                if (done_reg)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                state_next = ST_RESP;
            end
            ST_SEARCH:
            begin
                if (pend_reg && (hit || (cmp_idx_reg == last_idx)))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_DISP_RD:
            begin
                state_next = ST_DISP_OUT;
            end
            ST_DISP_OUT:
            begin
                if (out_free)
                begin
                    state_next = (ptr_reg == last_idx) ? ST_IDLE : ST_DISP_RD;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath control and register updates.
    always_comb
    begin
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        wptr_next       = wptr_reg;
        end_next        = end_reg;
        cmp_idx_next    = cmp_idx_reg;
        pos_next        = pos_reg;
        res_slot_next   = res_slot_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        dir_next        = dir_reg;
        pend_next       = pend_reg;
        done_next       = done_reg;
        mem_we          = 1'b0;
        waddr           = wptr_reg;
        wdata           = rdata_reg;
        out_load        = 1'b0;
        out_din         = '{status: res_status_reg,
                            found_slot: FSLOT_W'(res_slot_reg),
                            entry_value: '0,
                            last: 1'b1};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    pos_next        = IDX_W'(req.slot);
                    val_next        = req.item_value;
                    res_slot_next   = '0;
                    res_status_next = reject ? reject_status : STS_OK;
                    pend_next       = 1'b0;
                    done_next       = 1'b0;
                    dir_next        = (req_kind == REQ_INSERT);
                    if (req_kind == REQ_INSERT)
                    begin
                        // Walk downwards from the last entry to the insert slot.
                        ptr_next = last_idx;
                        end_next = IDX_W'(req.slot);
                    end
                    else if (req_kind == REQ_DELETE)
                    begin
                        // Walk upwards from the slot after the deleted one.
                        ptr_next = IDX_W'(req.slot) + IDX_ONE;
                        end_next = last_idx;
                    end
                    else
                    begin
                        ptr_next = '0;
                    end
                end
            end
            ST_SHIFT:
            begin
                // Write the word read in the previous cycle one place along.
                mem_we = pend_reg;
                if (!done_reg)
                begin
                    pend_next = 1'b1;
                    wptr_next = dir_reg ? (ptr_reg + IDX_ONE) : (ptr_reg - IDX_ONE);
                    if (ptr_reg == end_reg)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        ptr_next = dir_reg ? (ptr_reg - IDX_ONE) : (ptr_reg + IDX_ONE);
                    end
                end
            end
            ST_PUT:
            begin
                if (dir_reg)
                begin
                    mem_we     = 1'b1;
                    waddr      = pos_reg;
                    wdata      = val_reg;
                    count_next = count_reg + CNT_ONE;
                end
                else
                begin
                    count_next = count_reg - CNT_ONE;
                end
            end
            ST_SEARCH:
            begin
                pend_next    = 1'b1;
                cmp_idx_next = ptr_reg;
                if (ptr_reg != last_idx)
                begin
                    ptr_next = ptr_reg + IDX_ONE;
                end
                if (pend_reg)
                begin
                    if (hit)
                    begin
                        res_status_next = STS_OK;
                        res_slot_next   = cmp_idx_reg;
                    end
                    else if (cmp_idx_reg == last_idx)
                    begin
                        res_status_next = STS_NOTFOUND;
                        res_slot_next   = '0;
                    end
                end
            end
            ST_DISP_RD:
            begin
                pend_next = 1'b0;
            end
            ST_DISP_OUT:
            begin
                out_load = out_free;
                out_din  = '{status: STS_OK,
                             found_slot: FSLOT_W'(ptr_reg),
                             entry_value: signed'(rdata_reg),
                             last: (ptr_reg == last_idx)};
                if (out_free && (ptr_reg != last_idx))
                begin
                    ptr_next = ptr_reg + IDX_ONE;
                end
            end
            ST_RESP:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        wptr_reg       <= wptr_next;
        end_reg        <= end_next;
        cmp_idx_reg    <= cmp_idx_next;
        pos_reg        <= pos_next;
        res_slot_reg   <= res_slot_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        dir_reg        <= dir_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[ptr_reg];
    end

    oaids_out_stage u_out_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (out_load),
        .din   (out_din),
        .free  (out_free),
        .rsp   (rsp)
    );

    // The fill count never passes the list depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("fill count above depth");

    // The fill count moves only as an insert or delete completes.
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_PUT))
        else $error("fill count changed outside completion");

    // Memory writes happen only while shifting or placing the new value.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> ((state_reg == ST_SHIFT) || (state_reg == ST_PUT)))
        else $error("memory write outside shift");

    // A shift never writes the entry it is reading in the same cycle.
    a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SHIFT) && mem_we && !done_reg) |-> (waddr != ptr_reg))
        else $error("shift write collides with read");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the positional list. Every accepted request is fed to a
// shadow copy of the list, which queues the results the block owes us; a monitor on
// the result channel compares each accepted result against the oldest entry.
module testbench;
    import oaids_pkg::*;

    localparam int LIST_DEPTH = DEPTH_DEF;
    localparam int HALF_PERIOD = 6;

    logic clk;
    logic rst_n;

    // Percentages of cycles in which the request side holds back and the result
    // side withholds ready. They are changed between the phases of the run.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatch_count;

    // Shadow of the list contents: its size is the fill count.
    logic signed [DATA_W-1:0] shadow_list[$];
    // Results owed by the block, oldest first.
    result_t pending_results[$];

    oaids_req_if req_ch();
    oaids_rsp_if rsp_ch();

    ordered_array_insert_delete_search_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Work out what one accepted request must produce and update the shadow list.
    // Failed inserts and deletes leave the list untouched; display yields one
    // result per entry, and only the final one carries the last flag.
    function automatic void predict_request(input req_type_t op,
                                            input logic [SLOT_W-1:0] slot,
                                            input logic signed [DATA_W-1:0] value);
        result_t res;
        int fill;
        int hit;
        fill = shadow_list.size();
        hit = -1;
        res.status = STS_OK;
        res.found_slot = '0;
        res.entry_value = '0;
        res.last = 1'b1;
        case (op)
            REQ_INSERT:
            begin
                if (fill >= LIST_DEPTH)
                    res.status = STS_FULL;
                else if (int'(slot) > fill)
                    res.status = STS_BADPOS;
                else
                    shadow_list.insert(int'(slot), value);
                pending_results.push_back(res);
            end
            REQ_DELETE:
            begin
                if (fill == 0)
                    res.status = STS_EMPTY;
                else if (int'(slot) >= fill)
                    res.status = STS_BADPOS;
                else
                    shadow_list.delete(int'(slot));
                pending_results.push_back(res);
            end
            REQ_DISPLAY:
            begin
                if (fill == 0)
                begin
                    res.status = STS_EMPTY;
                    pending_results.push_back(res);
                end
                else
                begin
                    for (int i = 0; i < fill; i++)
                    begin
                        res.found_slot = FSLOT_W'(i);
                        res.entry_value = shadow_list[i];
                        res.last = (i == fill - 1);
                        pending_results.push_back(res);
                    end
                end
            end
            default:
            begin
                if (fill == 0)
                    res.status = STS_EMPTY;
                else
                begin
                    // Only the first matching position counts.
                    for (int i = 0; i < fill; i++)
                    begin
                        if (hit < 0 && shadow_list[i] == value)
                            hit = i;
                    end
                    if (hit < 0)
                        res.status = STS_NOTFOUND;
                    else
                        res.found_slot = FSLOT_W'(hit);
                end
                pending_results.push_back(res);
            end
        endcase
    endfunction

    // Values for inserts and searches: a fair share are copies of entries already in
    // the list, so that duplicates and search hits are common, plus the extremes.
    function automatic logic signed [DATA_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 35 && shadow_list.size() > 0)
            return shadow_list[$urandom_range(shadow_list.size() - 1)];
        if (roll < 45)
        begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Present one request and hold it until it is taken. The task is entered and
    // left at a rising edge; ready is looked at on the falling edge, where it is
    // settled, and the request is taken at the rising edge that follows. Valid is
    // only lowered when the sender decides to idle, so it never drops and rises
    // again within one step.
    task automatic send_request(input req_type_t op,
                                input logic [SLOT_W-1:0] slot,
                                input logic signed [DATA_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= op;
        req_ch.slot       <= slot;
        req_ch.item_value <= value;
        @(negedge clk);
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);
        predict_request(op, slot, value);
    endtask

    // Every operation on an empty list reports empty, bar insert, which only
    // fails if the position lies past the end. Position 64, the list depth, is tried too.
    task automatic test_empty_list();
        send_request(REQ_DELETE, 7'd0, 32'sd0);
        send_request(REQ_SEARCH, 7'd0, 32'sd0);
        send_request(REQ_DISPLAY, 7'd64, 32'sd0);
        send_request(REQ_INSERT, 7'd1, 32'sd5);
        send_request(REQ_INSERT, 7'd64, -32'sd1);
        send_request(REQ_DELETE, 7'd64, 32'sd0);
    endtask

    // Inserts at the front, in the middle and at the end with extreme values,
    // duplicates so that search must return the first hit, a search miss, deletes
    // at both ends and out of range, and displays in between.
    task automatic test_edit_and_search();
        send_request(REQ_INSERT, 7'd0, 32'h7FFF_FFFF);
        send_request(REQ_INSERT, 7'd0, 32'h8000_0000);
        send_request(REQ_INSERT, 7'd2, 32'sd0);
        send_request(REQ_INSERT, 7'd1, -32'sd1);
        send_request(REQ_INSERT, 7'd4, -32'sd1);
        send_request(REQ_INSERT, 7'd6, 32'sd1);
        send_request(REQ_DISPLAY, 7'd0, 32'sd0);
        send_request(REQ_SEARCH, 7'd0, -32'sd1);
        send_request(REQ_SEARCH, 7'd0, 32'sd0);
        send_request(REQ_SEARCH, 7'd0, 32'sd12345);
        send_request(REQ_DELETE, 7'd5, 32'sd0);
        send_request(REQ_DELETE, 7'd1, 32'sd0);
        send_request(REQ_DELETE, 7'd3, 32'sd0);
        send_request(REQ_DELETE, 7'd0, 32'sd0);
        send_request(REQ_DISPLAY, 7'd0, 32'sd0);
        send_request(REQ_SEARCH, 7'd0, -32'sd1);
    endtask

    // Fill the list to the brim at random positions, then check that a full list
    // refuses inserts even at a valid position, that display gives all entries,
    // and that the final position can be found and removed.
    task automatic test_full_list();
        logic signed [DATA_W-1:0] marker;
        marker = 32'h5A5A_A5A5;
        while (shadow_list.size() < LIST_DEPTH - 1)
            send_request(REQ_INSERT, SLOT_W'($urandom_range(shadow_list.size())), $urandom);
        send_request(REQ_INSERT, SLOT_W'(shadow_list.size()), marker);
        send_request(REQ_INSERT, 7'd0, 32'sd7);
        send_request(REQ_INSERT, 7'd64, 32'sd7);
        send_request(REQ_DISPLAY, 7'd0, 32'sd0);
        send_request(REQ_SEARCH, 7'd0, marker);
        send_request(REQ_DELETE, 7'd64, 32'sd0);
        send_request(REQ_DELETE, 7'd63, 32'sd0);
        send_request(REQ_DELETE, 7'd0, 32'sd0);
    endtask

    // Mixed traffic. Inserts become rarer as the list fills, so the fill count
    // is drawn back towards the middle of its range. Most positions are valid for the
    // chosen operation; the rest fall at or past the end of the list.
    task automatic test_random_traffic(input int count);
        req_type_t op;
        logic [SLOT_W-1:0] slot;
        int fill;
        int roll;
        for (int n = 0; n < count; n++)
        begin
            fill = shadow_list.size();
            roll = $urandom_range(99);
            if (roll < 45 - fill / 3)
                op = REQ_INSERT;
            else if (roll < 70)
                op = REQ_DELETE;
            else if (roll < 90)
                op = REQ_SEARCH;
            else
                op = REQ_DISPLAY;
            if ($urandom_range(99) < 85)
            begin
                if (op == REQ_DELETE && fill > 0)
                    slot = SLOT_W'($urandom_range(fill - 1));
                else
                    slot = SLOT_W'($urandom_range(fill));
            end
            else
                slot = SLOT_W'($urandom_range(LIST_DEPTH, fill));
            send_request(op, slot, pick_value());
        end
    endtask

    // The result side withholds ready at random, as the current phase dictates.
    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    // Results are compared on the falling edge, where the payload is settled; a
    // result seen here with ready high is the one taken at the next rising edge.
    always @(negedge clk)
    begin : check_result
        result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, found_slot %0d, entry_value %0d",
                       rsp_ch.status, rsp_ch.found_slot, rsp_ch.entry_value);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.found_slot !== want.found_slot)
                begin
                    $error("found_slot: expected %0d, actual %0d",
                           want.found_slot, rsp_ch.found_slot);
                    mismatch_count++;
                end
                if (rsp_ch.entry_value !== want.entry_value)
                begin
                    $error("entry_value: expected %0d, actual %0d",
                           want.entry_value, rsp_ch.entry_value);
                    mismatch_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.slot = '0;
        req_ch.item_value = '0;
        rsp_ch.ready = 1'b0;
        mismatch_count = 0;

        // First phase: a lazy receiver, a mostly eager sender.
        send_idle_pct = 10;
        recv_idle_pct = 55;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edit_and_search();
        test_random_traffic(8);

        // Second phase: the roles swap.
        send_idle_pct = 55;
        recv_idle_pct = 10;
        test_full_list();
        test_random_traffic(8);

        // Final phase: both sides flat out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(10);

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // Leave room for any stray result after the last expected one.
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("PASS ordered_array_insert_delete_search_top");
        else
            $display("FAIL ordered_array_insert_delete_search_top");
        $finish;
    end

    // Watchdog: well beyond the slowest legal run, in case the block hangs.
    initial
    begin
        #15_000_000;
        $display("FAIL ordered_array_insert_delete_search_top");
        $finish;
    end

endmodule
